FILE: src/wsfd_pkg.sv
package wsfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int KEEP_W      = 16;               // max_kept register width
    localparam int LEN_W       = 64;               // header payload length
    localparam int POS_W       = KEEP_W + 1;       // saturating payload position
    localparam int EXT_W       = 4;
    localparam int USER_W      = 3;

    localparam logic [6:0]        LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0]        LEN_CODE_EXT64 = 7'd127;
    localparam logic [EXT_W-1:0]  EXT16_BYTES    = 4'd2;
    localparam logic [EXT_W-1:0]  EXT64_BYTES    = 4'd8;
    localparam logic [1:0]        MASK_LAST_IDX  = 2'd3;   // fourth mask byte
    localparam logic [KEEP_W-1:0] MAX_KEPT_RESET = 16'd8191;

    // m_tuser bit positions
    localparam int USER_DATA_VALID  = 0;
    localparam int USER_TRUNCATED   = 1;
    localparam int USER_EMPTY_FRAME = 2;

endpackage

FILE: src/websocket_frame_deframer_core.sv
// Channel   | Signals                          | Item
// ----------+----------------------------------+--------------------------------------
// s (in)    | s_tvalid s_tready s_tdata[7:0]   | one raw frame byte (rx_byte)
// m (out)   | m_tvalid m_tready m_tdata[7:0]   | out_byte; m_tlast = frame_end
//           | m_tlast m_tuser[2:0]             | m_tuser = {empty, truncated, valid}
// cfg       | cfg_we cfg_wdata[15:0]           | max_kept, written on cfg_we
//
// One input byte per clock unless stalled. Each accepted byte is decoded in
// the cycle it is taken and its result (if any) lands in the output register at
// that edge. s_tready is high whenever the output register is empty or being drained,
// so a stalled m side holds one result and stops input only while m_tready
// is low. Reset (rst_n low, async) returns to "expect first header byte"
// and sets max_kept to 8191.
module websocket_frame_deframer_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wsfd_pkg::BYTE_W-1:0]       s_tdata,    // [7:0] rx_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wsfd_pkg::BYTE_W-1:0]       m_tdata,    // [7:0] out_byte
    output logic                              m_tlast,    // frame_end
    output logic [wsfd_pkg::USER_W-1:0]       m_tuser,    // [0] data_valid,
                                                          // [1] truncated,
                                                          // [2] empty_frame
    input  logic                              cfg_we,
    input  logic [wsfd_pkg::KEEP_W-1:0]       cfg_wdata   // max_kept
);

    import wsfd_pkg::*;

    typedef enum logic [2:0]
    {
        PH_HEAD,
        PH_LEN,
        PH_EXT,
        PH_MASK,
        PH_DATA
    } phase_t;

    // Frame state
    phase_t              phase_reg,      phase_next;
    logic [EXT_W-1:0]    ext_left_reg,   ext_left_next;
    // Holds header length, then counts down bytes still to come in payload
    logic [LEN_W-1:0]    len_reg,        len_next;
    logic [31:0]         mask_key_reg,   mask_key_next;
    logic [1:0]          mask_cnt_reg,   mask_cnt_next;
    // Payload position, saturates once past any possible max_kept
    logic [POS_W-1:0]    pos_reg,        pos_next;
    logic [KEEP_W-1:0]   max_kept_reg;

    // Output register
    logic                out_valid_reg,  out_valid_next;
    logic [BYTE_W-1:0]   out_data_reg,   out_data_next;
    logic                out_last_reg,   out_last_next;
    logic [USER_W-1:0]   out_user_reg,   out_user_next;

    logic                accept;
    logic                produce;
    logic [6:0]          len_code;
    logic                last_byte;
    logic                keep_byte;
    logic [BYTE_W-1:0]   mask_byte;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    assign len_code  = s_tdata[6:0];
    assign last_byte = (len_reg == LEN_W'(1));
    assign keep_byte = !pos_reg[POS_W-1] && (pos_reg[KEEP_W-1:0] < max_kept_reg);

    // Mask byte (position mod 4); first received mask byte sits on top
    always_comb
    begin
        case (pos_reg[1:0])
            2'd0:    mask_byte = mask_key_reg[31:24];
            2'd1:    mask_byte = mask_key_reg[23:16];
            2'd2:    mask_byte = mask_key_reg[15:8];
            default: mask_byte = mask_key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        ext_left_next = ext_left_reg;
        len_next      = len_reg;
        mask_key_next = mask_key_reg;
        mask_cnt_next = mask_cnt_reg;
        pos_next      = pos_reg;
        produce       = 1'b0;
        out_data_next = '0;
        out_last_next = 1'b0;
        out_user_next = '0;

        case (phase_reg)
            PH_HEAD:
            begin
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                mask_cnt_next = '0;
                len_next      = '0;
                if (len_code == LEN_CODE_EXT16)
                begin
                    ext_left_next = EXT16_BYTES;
                    phase_next    = PH_EXT;
                end
                else if (len_code == LEN_CODE_EXT64)
                begin
                    ext_left_next = EXT64_BYTES;
                    phase_next    = PH_EXT;
                end
                else
                begin
                    len_next   = LEN_W'(len_code);
                    phase_next = PH_MASK;
                end
            end
            PH_EXT:
            begin
                len_next      = {len_reg[LEN_W-BYTE_W-1:0], s_tdata};
                ext_left_next = ext_left_reg - EXT_W'(1);
                if (ext_left_reg == EXT_W'(1))
                    phase_next = PH_MASK;
            end
            PH_MASK:
            begin
                mask_key_next = {mask_key_reg[23:0], s_tdata};
                if (mask_cnt_reg == MASK_LAST_IDX)
                begin
                    mask_cnt_next = '0;
                    pos_next      = '0;
                    if (len_reg == '0)
                    begin
                        // zero-length frame: one empty closing result
                        phase_next                      = PH_HEAD;
                        produce                         = 1'b1;
                        out_last_next                   = 1'b1;
                        out_user_next[USER_EMPTY_FRAME] = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else
                begin
                    mask_cnt_next = mask_cnt_reg + 2'd1;
                end
            end
            PH_DATA:
            begin
                len_next = len_reg - LEN_W'(1);
                if (!pos_reg[POS_W-1])
                    pos_next = pos_reg + POS_W'(1);
                if (last_byte)
                    phase_next = PH_HEAD;
                if (keep_byte)
                begin
                    // kept byte: position < max_kept, so length > max_kept
                    // can't hold on the last byte
                    produce                        = 1'b1;
                    out_data_next                  = s_tdata ^ mask_byte;
                    out_last_next                  = last_byte;
                    out_user_next[USER_DATA_VALID] = 1'b1;
                end
                else if (last_byte)
                begin
                    produce                       = 1'b1;
                    out_last_next                 = 1'b1;
                    out_user_next[USER_TRUNCATED] = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_LEN;
            end
        endcase
    end

    assign out_valid_next = (accept && produce) || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEAD;
            ext_left_reg  <= '0;
            len_reg       <= '0;
            mask_key_reg  <= '0;
            mask_cnt_reg  <= '0;
            pos_reg       <= '0;
            max_kept_reg  <= MAX_KEPT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                max_kept_reg <= cfg_wdata;
            if (accept)
            begin
                phase_reg    <= phase_next;
                ext_left_reg <= ext_left_next;
                len_reg      <= len_next;
                mask_key_reg <= mask_key_next;
                mask_cnt_reg <= mask_cnt_next;
                pos_reg      <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && produce)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
            out_user_reg <= out_user_next;
        end
    end

`ifndef SYNTHESIS
    a_ext_only_in_ext: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_EXT) |-> (ext_left_reg == '0))
        else $error("ext_left nonzero outside extended length phase");

    a_last_returns_head: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_DATA && last_byte) |=>
            (phase_reg == PH_HEAD && out_valid_reg && out_last_reg))
        else $error("last payload byte did not close the frame");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($countones(m_tuser) <= 1))
        else $error("data_valid, truncated and empty_frame overlap");

    a_status_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[USER_TRUNCATED] || m_tuser[USER_EMPTY_FRAME]))
            |-> m_tlast)
        else $error("truncated or empty result without frame end");

    a_no_silent_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");
`endif

endmodule

FILE: bench/wsfd_tb_pkg.sv
package wsfd_tb_pkg;

    import wsfd_pkg::*;

    typedef enum logic [2:0] {ST_HEAD, ST_LEN, ST_EXT, ST_MASK, ST_DATA} parse_st_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              last;
        logic              trunc;
        logic              empty;
    } unmasked_t;

    class unmask_scoreboard_t;
        logic [KEEP_W-1:0] keep_limit;
        parse_st_t         st;
        logic [EXT_W-1:0]  ext_cnt;
        logic [LEN_W-1:0]  frame_len;
        logic [31:0]       key;
        logic [1:0]        key_cnt;
        logic [LEN_W-1:0]  pos;
        unmasked_t         unmasked_q[$];
        int unsigned       errors, n_in, n_out, n_frames, n_empty, n_trunc;

        function new();
            keep_limit = MAX_KEPT_RESET;
            st         = ST_HEAD;
            ext_cnt    = '0;
            frame_len  = '0;
            key        = '0;
            key_cnt    = '0;
            pos        = '0;
        endfunction

        function int pending();
            return unmasked_q.size();
        endfunction

        // bytes still needed to finish the parser's current phase (small lengths only)
        function int unsigned bytes_to_boundary();
            case (st)
                ST_LEN:  return 1;
                ST_EXT:  return ext_cnt;
                ST_MASK: return 4 - key_cnt;
                ST_DATA: return int'(frame_len - pos);
                default: return 0;
            endcase
        endfunction

        // advance the parser by one accepted byte, queue what it should emit
        function void note_byte(logic [BYTE_W-1:0] b);
            unmasked_t r;
            logic      at_end;
            r = '0;
            n_in++;
            case (st)
                ST_HEAD: st = ST_LEN;
                ST_LEN:
                begin
                    frame_len = '0;
                    key_cnt   = '0;
                    if (b[6:0] == LEN_CODE_EXT16)
                    begin
                        ext_cnt = EXT16_BYTES;
                        st      = ST_EXT;
                    end
                    else if (b[6:0] == LEN_CODE_EXT64)
                    begin
                        ext_cnt = EXT64_BYTES;
                        st      = ST_EXT;
                    end
                    else
                    begin
                        frame_len = LEN_W'(b[6:0]);
                        st        = ST_MASK;
                    end
                end
                ST_EXT:
                begin
                    frame_len = {frame_len[LEN_W-9:0], b};
                    ext_cnt   = ext_cnt - 1'b1;
                    if (ext_cnt == '0)
                        st = ST_MASK;
                end
                ST_MASK:
                begin
                    key = {key[23:0], b};
                    if (key_cnt == MASK_LAST_IDX)
                    begin
                        key_cnt = '0;
                        pos     = '0;
                        if (frame_len == '0)
                        begin
                            st      = ST_HEAD;
                            r.last  = 1'b1;
                            r.empty = 1'b1;
                            unmasked_q.push_back(r);
                        end
                        else
                            st = ST_DATA;
                    end
                    else
                        key_cnt = key_cnt + 1'b1;
                end
                ST_DATA:
                begin
                    at_end = (pos + 1 == frame_len);
                    if (at_end)
                        st = ST_HEAD;
                    if (pos < LEN_W'(keep_limit))
                    begin
                        r.data  = b ^ key[8 * (3 - int'(pos[1:0])) +: 8];
                        r.valid = 1'b1;
                        r.last  = at_end;
                        r.trunc = at_end && (frame_len > LEN_W'(keep_limit));
                        unmasked_q.push_back(r);
                    end
                    else if (at_end)
                    begin
                        r.last  = 1'b1;
                        r.trunc = 1'b1;
                        unmasked_q.push_back(r);
                    end
                    pos = pos + 1;
                end
                default: st = ST_LEN;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30)
                $display("MISMATCH %s", msg);
        endtask

        task check_result(logic [BYTE_W-1:0] data, logic last, logic [USER_W-1:0] user);
            unmasked_t got, want;
            got = {data, user[USER_DATA_VALID], last, user[USER_TRUNCATED],
                   user[USER_EMPTY_FRAME]};
            n_out++;
            if (unmasked_q.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", n_out));
                return;
            end
            want = unmasked_q.pop_front();
            if (got.data !== want.data || got.valid !== want.valid || got.last !== want.last
                || got.trunc !== want.trunc || got.empty !== want.empty)
                report($sformatf({"result %0d: got data %h valid %b last %b trunc %b empty %b,",
                                  " want %h %b %b %b %b"}, n_out, got.data, got.valid,
                                 got.last, got.trunc, got.empty, want.data, want.valid,
                                 want.last, want.trunc, want.empty));
            if (want.last)
            begin
                n_frames++;
                n_empty += want.empty;
                n_trunc += want.trunc;
            end
        endtask
    endclass

endpackage

FILE: bench/tb_websocket_frame_deframer_core.sv
module tb_websocket_frame_deframer_core;

    timeunit 1ns;
    timeprecision 1ps;

    import wsfd_pkg::*;
    import wsfd_tb_pkg::*;

    // cycles without any handshake on either side before the run is called hung;
    // longest legit quiet stretch is a drain pause plus a run of m-side stalls
    localparam int STUCK_LIMIT = 2000;

    // how the header encodes the payload length
    typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic [BYTE_W-1:0]   s_tdata   = '0;     // [7:0] rx_byte
    logic                m_tready  = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [KEEP_W-1:0]   cfg_wdata = '0;     // max_kept
    logic                s_tready;
    logic                m_tvalid;
    logic [BYTE_W-1:0]   m_tdata;            // [7:0] out_byte
    logic                m_tlast;            // frame_end
    logic [USER_W-1:0]   m_tuser;            // [0] data_valid, [1] truncated, [2] empty_frame

    bit                  calm      = 1'b0;   // both sides run flat out while set
    int unsigned         n_pushed  = 0;
    int unsigned         n_cfg     = 0;
    int unsigned         stuck     = 0;

    unmask_scoreboard_t  sb = new();

    websocket_frame_deframer_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // sink back-pressure: ~38% stall cycles unless in the calm stretch
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(99) >= 38);

    // Both handshakes sampled with pre-edge values. Results at this edge come
    // from bytes taken at earlier edges, so check before predicting.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata);
        end
    end

    // hang detector
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck = 0;
        else
            stuck++;
        if (stuck >= STUCK_LIMIT)
        begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     STUCK_LIMIT, sb.pending());
            $display("websocket_frame_deframer_core regression: fail");
            $finish;
        end
    end

    // offer one byte, with random idle cycles ahead of it; returns at the
    // edge that takes it, valid left high for a back-to-back follower
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(99) < 38)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        n_pushed++;
    endtask

    // hold the sender until every queued result has come out; extra cycles
    // cover dropped bytes still in flight that produce nothing
    task automatic drain(input int unsigned extra);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (extra) @(posedge clk);
    endtask

    // only while quiet; the predictor picks up the new limit at the same edge
    task automatic set_max_kept(input logic [KEEP_W-1:0] v);
        drain(4);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we         <= 1'b0;
        sb.keep_limit  = v;
        n_cfg++;
    endtask

    // header byte, length byte (random mask bit), big-endian extended length,
    // four key bytes, then n_pay payload bytes (may be fewer than len)
    task automatic send_frame(input logic [LEN_W-1:0] len, input len_form_t form,
                              input int unsigned n_pay);
        logic [6:0] code;
        int         nx;
        code = (form == FORM_EXT16) ? LEN_CODE_EXT16 :
               (form == FORM_EXT64) ? LEN_CODE_EXT64 : len[6:0];
        nx   = (form == FORM_EXT16) ? 2 : (form == FORM_EXT64) ? 8 : 0;
        push_byte(8'($urandom));
        push_byte({1'($urandom), code});
        for (int i = nx - 1; i >= 0; i--)
            push_byte(len[8 * i +: 8]);
        repeat (4) push_byte(8'($urandom));
        repeat (n_pay) push_byte(8'($urandom));
    endtask

    initial
    begin
        logic [LEN_W-1:0]  len;
        logic [KEEP_W-1:0] lim;
        int unsigned       pick, target, n;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // zero length via 16-bit extension, max_kept still at reset value
        send_frame(64'd0, FORM_EXT16, 0);
        // 64-bit extension, two bytes unmasked
        send_frame(64'd2, FORM_EXT64, 2);
        // keep one byte, drop the next, widen max_kept mid-frame, keep one
        // more, then the last byte lands past the limit: truncated close
        set_max_kept(16'd1);
        send_frame(64'd4, FORM_SHORT, 2);
        set_max_kept(16'd3);
        push_byte(8'h00);
        push_byte(8'hFF);

        // ---- random: six phases with different max_kept ----
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       lim = 16'd5;
                1:       lim = 16'd0;
                2:       lim = 16'hFFFF;
                3:       lim = 16'($urandom_range(1, 12));
                4:       lim = 16'($urandom);
                default: lim = MAX_KEPT_RESET;
            endcase
            set_max_kept(lim);
            calm   = (ph == 4);
            target = n_pushed + 120;
            while (n_pushed < target)
            begin
                pick = $urandom_range(99);
                if (pick < 6)
                    send_frame(64'd0, len_form_t'($urandom_range(2)), 0);
                else if (pick < 55)
                begin
                    len = (pick < 9) ? 64'd125 : 64'($urandom_range(1, 24));
                    send_frame(len, FORM_SHORT, int'(len));
                end
                else if (pick < 78)
                begin
                    len = 64'($urandom_range(0, (pick < 60) ? 300 : 40));
                    send_frame(len, FORM_EXT16, int'(len));
                end
                else if (pick < 90)
                begin
                    len = 64'($urandom_range(0, 30));
                    send_frame(len, FORM_EXT64, int'(len));
                end
                else
                begin
                    // broken frame: stray bytes with bit 6 clear (so no
                    // extended length code), then walk the parser back to a
                    // frame boundary using its own state while quiet
                    repeat ($urandom_range(1, 5)) push_byte(8'($urandom) & 8'hBF);
                    do
                    begin
                        drain(0);
                        n = sb.bytes_to_boundary();
                        repeat (n) push_byte(8'($urandom) & 8'hBF);
                    end
                    while (n != 0);
                end
            end
        end
        calm = 1'b0;

        // 64-bit length with the top bit set: never ends, every byte kept
        set_max_kept(16'hFFFF);
        send_frame(64'h8000_0000_0000_0011, FORM_EXT64, 40);

        drain(8);
        $display("%0d bytes in, %0d results out, %0d frames closed (%0d empty, %0d truncated)",
                 sb.n_in, sb.n_out, sb.n_frames, sb.n_empty, sb.n_trunc);
        $display("max_kept written %0d times incl. 0, 65535 and a mid-frame change",
                 n_cfg);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("websocket_frame_deframer_core regression: pass");
        else
            $display("websocket_frame_deframer_core regression: fail");
        $finish;
    end

endmodule
